FILE: hdl/pcmp_pkg.sv
// ----------------------------------------------------------------------------
// pcmp_pkg
// Shared types and constants for the predictor compressor.
// ----------------------------------------------------------------------------
package pcmp_pkg;

    // Bytes per group, one flag bit each
    localparam int GROUP_SIZE     = 8;
    localparam int GRP_POS_W      = $clog2(GROUP_SIZE);
    localparam int GRP_CNT_W      = GRP_POS_W + 1;
    // Default width of the history hash and guess table index
    localparam int TABLE_BITS_DEF = 16;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } t_in;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_flag;
        logic       group_end;
        logic       frame_end;
    } t_out;

    // Closed group handed from the collector to the emitter
    typedef struct packed {
        logic [GROUP_SIZE-1:0]      flags;
        logic [GROUP_SIZE-1:0][7:0] lits;
        logic [GRP_CNT_W-1:0]       lit_cnt;
        logic                       frame_end;
    } t_group;

endpackage

FILE: hdl/pcmp_table.sv
// ----------------------------------------------------------------------------
// pcmp_table
// Guess table memory with history hash, registered read, write bypass
// and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pcmp_table #(
    parameter int TABLE_BITS = pcmp_pkg::TABLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_byte,
    output logic       o_hit,
    output logic       o_ready
);

    localparam int DEPTH = 1 << TABLE_BITS;

    logic [7:0]            mem [DEPTH];
    logic [7:0]            r_rd_data;
    logic                  r_byp_valid;
    logic [7:0]            r_byp_data;
    logic [TABLE_BITS-1:0] r_hash;
    logic [TABLE_BITS-1:0] n_hash;
    logic                  r_clearing;
    logic [TABLE_BITS-1:0] r_clr_addr;

    logic [7:0]            guess;
    logic                  upd;
    logic                  we;
    logic [TABLE_BITS-1:0] waddr;
    logic [7:0]            wdata;
    logic [TABLE_BITS-1:0] raddr;

    // Compare against the predicted byte, forward a same-address write
    assign guess   = r_byp_valid ? r_byp_data : r_rd_data;
    assign o_hit   = (guess == i_byte);
    assign o_ready = !r_clearing;

    // Next hash: shift in one nibble, fold the byte in
    assign n_hash = {r_hash[TABLE_BITS-5:0], 4'b0000}
                  ^ {{(TABLE_BITS-8){1'b0}}, i_byte};

    // Write on a miss, or zero during the sweep
    assign upd   = i_acc && !o_hit;
    assign we    = r_clearing || upd;
    assign waddr = r_clearing ? r_clr_addr : r_hash;
    assign wdata = r_clearing ? 8'h00 : i_byte;
    assign raddr = i_acc ? n_hash : r_hash;

    // Table storage, read-old on collision
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data  <= mem[raddr];
        r_byp_data <= i_byte;
    end

    // Hash, bypass flag and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_byp_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_byp_valid <= upd && (n_hash == r_hash);
            if (i_acc) begin
                r_hash <= n_hash;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == TABLE_BITS'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: hdl/pcmp_group.sv
// ----------------------------------------------------------------------------
// pcmp_group
// Collects flag bits and missed literals of the open group and hands the
// group over when it closes.
// ----------------------------------------------------------------------------
module pcmp_group (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  pcmp_pkg::t_in         i_in,
    input  logic                  i_hit,
    output logic                  o_close,
    output logic                  o_load,
    output pcmp_pkg::t_group      o_grp
);

    logic [pcmp_pkg::GROUP_SIZE-1:0]      r_flags;
    logic [pcmp_pkg::GROUP_SIZE-1:0][7:0] r_lits;
    logic [pcmp_pkg::GRP_POS_W-1:0]       r_cnt;
    logic [pcmp_pkg::GRP_CNT_W-1:0]       r_lit_cnt;

    logic [pcmp_pkg::GROUP_SIZE-1:0]      n_flags;
    logic [pcmp_pkg::GROUP_SIZE-1:0][7:0] n_lits;
    logic [pcmp_pkg::GRP_CNT_W-1:0]       n_lit_cnt;

    // Close on a full group or on the frame's last byte
    assign o_close = (r_cnt == pcmp_pkg::GRP_POS_W'(pcmp_pkg::GROUP_SIZE - 1))
                   || i_in.frame_last;
    assign o_load  = i_acc && o_close;

    // Fold the current byte into the group
    always_comb begin
        n_flags   = r_flags;
        n_lits    = r_lits;
        n_lit_cnt = r_lit_cnt;
        if (i_hit) begin
            n_flags[r_cnt] = 1'b1;
        end else begin
            n_lits[r_lit_cnt[pcmp_pkg::GRP_POS_W-1:0]] = i_in.data_byte;
            n_lit_cnt = r_lit_cnt + 1'b1;
        end
    end

    assign o_grp.flags     = n_flags;
    assign o_grp.lits      = n_lits;
    assign o_grp.lit_cnt   = n_lit_cnt;
    assign o_grp.frame_end = i_in.frame_last;

    // Literal storage
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_lits <= n_lits;
        end
    end

    // Advance the group, restart it on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_cnt     <= '0;
            r_lit_cnt <= '0;
        end else if (i_acc) begin
            if (o_close) begin
                r_flags   <= '0;
                r_cnt     <= '0;
                r_lit_cnt <= '0;
            end else begin
                r_flags   <= n_flags;
                r_cnt     <= r_cnt + 1'b1;
                r_lit_cnt <= n_lit_cnt;
            end
        end
    end

endmodule

FILE: hdl/pcmp_emit.sv
// ----------------------------------------------------------------------------
// pcmp_emit
// Holds one closed group and sends its flag byte and literals, one word
// per cycle while the output is taken, through the output register.
// ----------------------------------------------------------------------------
module pcmp_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  pcmp_pkg::t_group      i_grp,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcmp_pkg::t_out        o_out_data
);

    pcmp_pkg::t_group                 r_grp;
    logic                             r_busy;
    logic [pcmp_pkg::GRP_CNT_W-1:0]   r_idx;
    logic                             r_out_valid;
    pcmp_pkg::t_out                   r_out_data;

    pcmp_pkg::t_out                   n_word;
    logic                             adv;
    logic                             last_word;
    logic [pcmp_pkg::GRP_POS_W-1:0]   lit_sel;

    assign o_free      = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Index zero is the flag byte, then literals in arrival order
    assign last_word = (r_idx == r_grp.lit_cnt);
    assign lit_sel   = pcmp_pkg::GRP_POS_W'(r_idx - 1'b1);
    assign adv       = r_busy && (!r_out_valid || i_out_ready);

    always_comb begin
        n_word.out_byte  = (r_idx == '0) ? r_grp.flags : r_grp.lits[lit_sel];
        n_word.is_flag   = (r_idx == '0);
        n_word.group_end = last_word;
        n_word.frame_end = last_word && r_grp.frame_end;
    end

    // Group bank and output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
        if (adv) begin
            r_out_data <= n_word;
        end
    end

    // Walk the group, hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv) begin
                if (last_word) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/predictor_compressor.sv
// ----------------------------------------------------------------------------
// predictor_compressor
// Predictor compressor: guess table lookup by running hash, flag byte plus
// missed literals emitted per group of up to eight bytes.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------
//   in      | i_in_valid / o_in_ready | i_in_data  (data_byte, frame_last)
//   out     | o_out_valid/ i_out_ready| o_out_data (out_byte, is_flag,
//           |                         |             group_end, frame_end)
//
// One input word is taken per cycle while neither the sweep nor a full
// emitter holds it off; the table read for the next byte is issued at
// acceptance. A closed group drains at one word per cycle while the output
// is ready (1 + L words); a byte that closes a group waits while the
// previous group is still draining.
// After reset the table is swept to zero with o_in_ready low. Output stalls
// back up through the emitter into the input.
// ----------------------------------------------------------------------------
module predictor_compressor #(
    parameter int TABLE_BITS = pcmp_pkg::TABLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pcmp_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pcmp_pkg::t_out    o_out_data
);

    logic             tbl_ready;
    logic             hit;
    logic             close;
    logic             load;
    logic             em_free;
    logic             acc;
    pcmp_pkg::t_group grp;

    // Accept unless sweeping, or closing a group while the emitter is full
    assign o_in_ready = tbl_ready && (!close || em_free);
    assign acc        = i_in_valid && o_in_ready;

    pcmp_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_in_data.data_byte),
        .o_hit   (hit),
        .o_ready (tbl_ready)
    );

    pcmp_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_in    (i_in_data),
        .i_hit   (hit),
        .o_close (close),
        .o_load  (load),
        .o_grp   (grp)
    );

    pcmp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_grp       (grp),
        .o_free      (em_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: verif/predictor_compressor_tb.sv
// ----------------------------------------------------------------------------
// predictor_compressor_tb
// Self-checking bench for the predictor compressor. Source words are pushed
// through the valid/ready input; a local model of the guess table and the
// running hash builds the compressed stream (flag byte plus missed literals
// per group), and every output word is checked field by field against it.
// Both sides idle at random, the output is held off long enough to back the
// block up into its input, and the sender also pauses until the stream drains.
// ----------------------------------------------------------------------------
module predictor_compressor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_BITS    = pcmp_pkg::TABLE_BITS_DEF;
    localparam int TBL_DEPTH   = 1 << TBL_BITS;
    localparam int CYCLE_LIMIT = 900_000;
    localparam int MAX_REPORTS = 40;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    pcmp_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    pcmp_pkg::t_out o_out_data;

    // Local copy of the compressor state
    logic [7:0]          guess_mem [TBL_DEPTH];
    logic [TBL_BITS-1:0] hist_hash;
    logic [7:0]          grp_flags;
    int                  grp_fill;
    logic [7:0]          miss_bytes [pcmp_pkg::GROUP_SIZE];
    int                  miss_fill;

    // Compressed stream words still to come out of the block
    pcmp_pkg::t_out stream_q [$];

    int err_count;
    int cycle_count;
    int words_sent;
    int frames_sent;
    int words_checked;
    int flag_words;
    int guess_hits;

    // Receiver control
    int rx_hold_req;
    int rx_stall;
    int rx_steady;

    predictor_compressor #(
        .TABLE_BITS (TBL_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Advance the local compressor by one source byte; queue closed group
    function automatic void compress_word(input pcmp_pkg::t_in w);
        pcmp_pkg::t_out r;
        int             k;
        if (guess_mem[hist_hash] == w.data_byte) begin
            grp_flags[grp_fill] = 1'b1;
            guess_hits++;
        end else begin
            guess_mem[hist_hash] = w.data_byte;
            miss_bytes[miss_fill] = w.data_byte;
            miss_fill++;
        end
        hist_hash = (hist_hash << 4) ^ TBL_BITS'(w.data_byte);
        grp_fill++;

        // Close the group: flag byte first, then literals in arrival order
        if (grp_fill == pcmp_pkg::GROUP_SIZE || w.frame_last) begin
            r.out_byte  = grp_flags;
            r.is_flag   = 1'b1;
            r.group_end = (miss_fill == 0);
            r.frame_end = (miss_fill == 0) && w.frame_last;
            stream_q.push_back(r);
            for (k = 0; k < miss_fill; k++) begin
                r.out_byte  = miss_bytes[k];
                r.is_flag   = 1'b0;
                r.group_end = (k == miss_fill - 1);
                r.frame_end = (k == miss_fill - 1) && w.frame_last;
                stream_q.push_back(r);
            end
            grp_flags = '0;
            grp_fill  = 0;
            miss_fill = 0;
        end
    endfunction

    // Offer one source word, hold it until taken, then idle for gap cycles
    task automatic send_word(input logic [7:0] b, input logic last, input int gap);
        pcmp_pkg::t_in w;
        w.data_byte = b;
        w.frame_last = last;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        compress_word(w);
        words_sent++;
        if (last) frames_sent++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold until every expected output word has arrived
    task automatic wait_drained();
        while (stream_q.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the byte, all-hit and all-miss groups, single-byte frame,
    // group closed by count alone and carry of the table across frames
    task automatic test_directed();
        logic [7:0] pat [7];
        int         i;
        pat = '{8'hFF, 8'h80, 8'h01, 8'h7F, 8'h55, 8'hAA, 8'hFF};
        send_word(8'h00, 1'b1, pick_gap());
        for (i = 0; i < 8; i++) send_word(8'h00, i == 7, pick_gap());
        for (i = 0; i < 7; i++) send_word(pat[i], i == 6, pick_gap());
        for (i = 0; i < 9; i++) send_word(pat[i % 7], i == 8, pick_gap());
    endtask

    // Repeated phrases with random content so that the guesses start to hit
    task automatic test_phrase_repeats(input int n_items);
        logic [7:0] phrase [12];
        logic [7:0] b;
        logic       last;
        int         len;
        int         reps;
        int         burst;
        int         sent;
        int         r;
        int         i;
        sent = 0;
        while (sent < n_items) begin
            len   = $urandom_range(4, 12);
            reps  = $urandom_range(2, 4);
            burst = ($urandom_range(0, 3) == 0) ? 1 : 0;
            for (i = 0; i < len; i++) phrase[i] = 8'($urandom_range(0, 255));
            for (r = 0; r < reps; r++) begin
                for (i = 0; i < len; i++) begin
                    b = phrase[i];
                    // Break the repetition now and then
                    if ($urandom_range(0, 19) == 0) b = 8'($urandom_range(0, 255));
                    if (r == reps - 1 && i == len - 1) begin
                        last = 1'($urandom_range(0, 1));
                    end else begin
                        last = ($urandom_range(0, 39) == 0);
                    end
                    send_word(b, last, (burst != 0) ? 0 : pick_gap());
                    sent++;
                end
            end
        end
    endtask

    // Unstructured bytes, some from a narrow alphabet, random frame ends
    task automatic test_random_noise(input int n_items);
        logic [7:0] alpha [4];
        logic [7:0] b;
        int         i;
        alpha = '{8'h00, 8'hFF, 8'h41, 8'h42};
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                b = alpha[$urandom_range(0, 3)];
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_word(b, $urandom_range(0, 99) < 15, pick_gap());
        end
    endtask

    // Hold off the output for a long stretch while words keep coming
    task automatic test_output_stall();
        logic [7:0] phrase [6];
        int         i;
        for (i = 0; i < 6; i++) phrase[i] = 8'($urandom_range(0, 255));
        rx_hold_req = 400;
        for (i = 0; i < 40; i++) begin
            if (i % 5 == 4) begin
                send_word(8'($urandom_range(0, 255)), i == 39, 0);
            end else begin
                send_word(phrase[i % 6], i == 39, 0);
            end
        end
    endtask

    // Pause the sender until the stream has drained, then resume
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 12; i++) begin
            send_word(8'($urandom_range(0, 255)), i == 11, (i == 11) ? 1 : 0);
        end
        wait_drained();
        repeat (5) @(posedge i_clk);
        for (i = 0; i < 8; i++) send_word(8'h00 + i[7:0], i == 7, i == 7 ? 1 : pick_gap());
    endtask

    // Output ready: random short and long stalls, steady stretches, and a
    // long hold-off on request
    always @(posedge i_clk) begin
        int r;
        if (rx_hold_req > 0) begin
            rx_stall    = rx_hold_req;
            rx_hold_req = 0;
            rx_steady   = 0;
        end
        if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else if (rx_steady > 0) begin
            rx_steady--;
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                rx_steady = $urandom_range(20, 60);
                i_out_ready <= 1'b1;
            end else if (r < 70) begin
                i_out_ready <= 1'b1;
            end else begin
                rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(1, 3);
                rx_stall--;
                i_out_ready <= 1'b0;
            end
        end
    end

    // Check each accepted output word against the oldest expected one
    always @(posedge i_clk) begin
        pcmp_pkg::t_out exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stream_q.size() == 0) begin
                report($sformatf("output word %h with nothing expected", o_out_data));
            end else begin
                exp_w = stream_q.pop_front();
                if (o_out_data.out_byte !== exp_w.out_byte)
                    report($sformatf("word %0d out_byte %h, expected %h", words_checked,
                                     o_out_data.out_byte, exp_w.out_byte));
                if (o_out_data.is_flag !== exp_w.is_flag)
                    report($sformatf("word %0d is_flag %b, expected %b", words_checked,
                                     o_out_data.is_flag, exp_w.is_flag));
                if (o_out_data.group_end !== exp_w.group_end)
                    report($sformatf("word %0d group_end %b, expected %b", words_checked,
                                     o_out_data.group_end, exp_w.group_end));
                if (o_out_data.frame_end !== exp_w.frame_end)
                    report($sformatf("word %0d frame_end %b, expected %b", words_checked,
                                     o_out_data.frame_end, exp_w.frame_end));
                if (exp_w.is_flag) flag_words++;
            end
            words_checked++;
        end
    end

    // Cycle budget; covers the table sweep after reset
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, stream_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Test sequence
    initial begin
        int i;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        err_count     = 0;
        cycle_count   = 0;
        words_sent    = 0;
        frames_sent   = 0;
        words_checked = 0;
        flag_words    = 0;
        guess_hits    = 0;
        rx_hold_req   = 0;
        rx_stall      = 0;
        rx_steady     = 0;
        hist_hash     = '0;
        grp_flags     = '0;
        grp_fill      = 0;
        miss_fill     = 0;
        for (i = 0; i < TBL_DEPTH; i++) guess_mem[i] = 8'h00;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_phrase_repeats(90);
        test_random_noise(50);
        test_output_stall();
        test_drain_pause();

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);

        $display("Sent %0d source words in %0d frames, %0d guess hits;", words_sent,
                 frames_sent, guess_hits);
        $display("checked %0d output words, %0d of them flag bytes, %0d mismatches.",
                 words_checked, flag_words, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
